### hdl/rds_group_block_encoder_assert.svh
// Assertion macros used by the checker file.
`ifndef RDS_GROUP_BLOCK_ENCODER_ASSERT_SVH
`define RDS_GROUP_BLOCK_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RGBE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RGBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rgbe_pkg.sv
package rgbe_pkg;

    // Group kinds on the request channel
    localparam logic [1:0] CMD_PS   = 2'd0;
    localparam logic [1:0] CMD_RT   = 2'd1;
    localparam logic [1:0] CMD_CT   = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_PI  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PTY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DI  = 3'd5;

    // Block positions within a group
    localparam logic [1:0] BLK_A = 2'd0;
    localparam logic [1:0] BLK_B = 2'd1;
    localparam logic [1:0] BLK_C = 2'd2;
    localparam logic [1:0] BLK_D = 2'd3;

    // Group type code and version, block B bits 15..11
    localparam logic [4:0] GT_0B = 5'b00001;
    localparam logic [4:0] GT_2A = 5'b00100;
    localparam logic [4:0] GT_4A = 5'b01000;

    // Offset words
    localparam logic [9:0] OFS_A  = 10'h0FC;
    localparam logic [9:0] OFS_B  = 10'h198;
    localparam logic [9:0] OFS_C  = 10'h168;
    localparam logic [9:0] OFS_CP = 10'h350;
    localparam logic [9:0] OFS_D  = 10'h1B4;

    // Generator x^10+x^8+x^7+x^5+x^4+x^3+1, feedback taps shifted into place
    localparam logic [9:0] CRC_POLY = 10'h1B8;

    // Day code arithmetic
    localparam logic [16:0] MJD_BASE   = 17'd14956;
    localparam logic [10:0] YEAR_DAYS4 = 11'd1461;
    localparam logic [16:0] YNEG_TERM  = 17'h1FE93; // -365 modulo 2^17

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  segment;
        logic        text_ab;
        logic [31:0] chars;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  offs;
        logic [16:0] yterm;
        logic [8:0]  mterm;
    } s1_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  segment;
        logic        text_ab;
        logic [31:0] chars;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  offs;
        logic [16:0] dc;
    } s2_t;

    typedef struct packed {
        logic [3:0][15:0] data;
        logic [3:0][9:0]  crc;
        logic             c_prime;
    } s3_t;

    typedef struct packed {
        logic [3:0][25:0] blocks;
    } group_t;

    // Load handshake between the checkword pipeline and the serialiser
    typedef struct packed {
        logic   valid;
        group_t grp;
    } grp_load_t;

    // Eight steps of the checkword shift register, MSB of the byte first
    function automatic logic [9:0] crc_byte(input logic [9:0] crc_in, input logic [7:0] b);
        logic [9:0] c;
        logic       fb;
        c = crc_in;
        for (int i = 7; i >= 0; i--)
        begin
            fb = b[i] ^ c[9];
            c  = {c[8:0], fb} ^ (fb ? CRC_POLY : 10'h000);
        end
        return c;
    endfunction

    // trunc((month + 1 + 12L) * 30.6001), L set for January and February
    function automatic logic [8:0] month_term(input logic [3:0] month);
        logic [8:0] t;
        case (month)
            4'd0:    t = 9'd30;
            4'd1:    t = 9'd428;
            4'd2:    t = 9'd459;
            4'd3:    t = 9'd122;
            4'd4:    t = 9'd153;
            4'd5:    t = 9'd183;
            4'd6:    t = 9'd214;
            4'd7:    t = 9'd244;
            4'd8:    t = 9'd275;
            4'd9:    t = 9'd306;
            4'd10:   t = 9'd336;
            4'd11:   t = 9'd367;
            4'd12:   t = 9'd397;
            4'd13:   t = 9'd428;
            4'd14:   t = 9'd459;
            default: t = 9'd489;
        endcase
        return t;
    endfunction

endpackage

### hdl/rgbe_if.sv
interface rgbe_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [3:0]  segment;
    logic        text_ab;
    logic [31:0] text_chars;
    logic [7:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic signed [5:0] utc_offset;

    modport source (output valid, command, segment, text_ab, text_chars, year, month, day,
                    hour, minute, utc_offset, input ready);
    modport sink (input valid, command, segment, text_ab, text_chars, year, month, day,
                  hour, minute, utc_offset, output ready);
endinterface

interface rgbe_blk_if;
    logic        valid;
    logic        ready;
    logic [25:0] block_word;
    logic [1:0]  block_index;
    logic        last_block;

    modport source (output valid, block_word, block_index, last_block, input ready);
    modport sink (input valid, block_word, block_index, last_block, output ready);
endinterface

interface rgbe_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rgbe_pkg::CFG_IDX_W-1:0]   index;
    logic [rgbe_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hdl/rgbe_block_ser.sv
module rgbe_block_ser (
    input  logic               clk,
    input  logic               rst_n,
    input  rgbe_pkg::grp_load_t ld,
    output logic               ld_ready,
    rgbe_blk_if.source         blk
);
    import rgbe_pkg::*;

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    group_t     grp_reg, grp_next;
    logic       take;

    assign take     = valid_reg && blk.ready;
    assign ld_ready = !valid_reg || (take && idx_reg == BLK_D);

    // Step through the four blocks; reload when empty or on the final beat
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        grp_next   = grp_reg;
        if (ld_ready)
        begin
            valid_next = ld.valid;
            idx_next   = BLK_A;
            if (ld.valid)
            begin
                grp_next = ld.grp;
            end
        end
        else if (take)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= BLK_A;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    assign blk.valid       = valid_reg;
    assign blk.block_word  = grp_reg.blocks[idx_reg];
    assign blk.block_index = idx_reg;
    assign blk.last_block  = (idx_reg == BLK_D);

endmodule

### hdl/rds_group_block_encoder.sv
// The first block of a group is offered once the request has passed stages 1 to 3 and is
// loaded in the serialiser; the one-block-per-beat output channel sends the four blocks
// back to back while ready; the pipeline takes a request every cycle until full.
// Requests with the unused command are taken and dropped, yielding no block.
// Reset (rst_n low, asynchronous) clears all stage valids and configuration registers
// to zero; no clearing pass follows.
module rds_group_block_encoder (
    input  logic        clk,
    input  logic        rst_n,
    rgbe_cfg_if.sink    cfg,
    rgbe_req_if.sink    req,
    rgbe_blk_if.source  blk
);
    import rgbe_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers; writes always accepted
    // ------------------------------------------------------------------
    logic [15:0] pi_reg,  pi_next;
    logic        tp_reg,  tp_next;
    logic [4:0]  pty_reg, pty_next;
    logic        ta_reg,  ta_next;
    logic        ms_reg,  ms_next;
    logic        di_reg,  di_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        pi_next  = pi_reg;
        tp_next  = tp_reg;
        pty_next = pty_reg;
        ta_next  = ta_reg;
        ms_next  = ms_reg;
        di_next  = di_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_PI:  pi_next  = cfg.data;
                REG_TP:  tp_next  = cfg.data[0];
                REG_PTY: pty_next = cfg.data[4:0];
                REG_TA:  ta_next  = cfg.data[0];
                REG_MS:  ms_next  = cfg.data[0];
                REG_DI:  di_next  = cfg.data[0];
                default: ; // indexes beyond the register list are dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pi_reg  <= '0;
            tp_reg  <= 1'b0;
            pty_reg <= '0;
            ta_reg  <= 1'b0;
            ms_reg  <= 1'b0;
            di_reg  <= 1'b0;
        end
        else
        begin
            pi_reg  <= pi_next;
            tp_reg  <= tp_next;
            pty_reg <= pty_next;
            ta_reg  <= ta_next;
            ms_reg  <= ms_next;
            di_reg  <= di_next;
        end
    end

    // ------------------------------------------------------------------
    // Stall chain: each stage advances when the one below has room
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s1_ready, s2_ready, s3_ready, ser_ready;

    assign s3_ready  = !s3_valid_reg || ser_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;

    // ------------------------------------------------------------------
    // Stage 1: capture the request, year and month terms of the day code.
    // (year - L) * 365.25 is exact as (year - L) * 1461 >> 2; the only
    // negative case, year zero in January or February, is -365.
    // ------------------------------------------------------------------
    s1_t         s1_reg, s1_next;
    logic        leap;
    logic        y_neg;
    logic [7:0]  y_adj;
    logic [18:0] y_prod;

    assign leap   = (req.month == 4'd1) || (req.month == 4'd2);
    assign y_neg  = leap && (req.year == 8'd0);
    assign y_adj  = req.year - {7'd0, leap};
    assign y_prod = {11'd0, y_adj} * {8'd0, YEAR_DAYS4};

    always_comb
    begin
        s1_next.cmd     = req.command;
        s1_next.segment = req.segment;
        s1_next.text_ab = req.text_ab;
        s1_next.chars   = req.text_chars;
        s1_next.day     = req.day;
        s1_next.hour    = req.hour;
        s1_next.minute  = req.minute;
        s1_next.offs    = req.utc_offset;
        s1_next.yterm   = y_neg ? YNEG_TERM : y_prod[18:2];
        s1_next.mterm   = month_term(req.month);
    end

    // Drop the unused command at the door
    assign s1_valid_next = s1_ready ? (req.valid && req.command != CMD_NONE) : s1_valid_reg;

    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sum the day code modulo 2^17
    // ------------------------------------------------------------------
    s2_t s2_reg, s2_next;

    always_comb
    begin
        s2_next.cmd     = s1_reg.cmd;
        s2_next.segment = s1_reg.segment;
        s2_next.text_ab = s1_reg.text_ab;
        s2_next.chars   = s1_reg.chars;
        s2_next.hour    = s1_reg.hour;
        s2_next.minute  = s1_reg.minute;
        s2_next.offs    = s1_reg.offs;
        s2_next.dc      = MJD_BASE + {12'd0, s1_reg.day} + s1_reg.yterm
                          + {8'd0, s1_reg.mterm};
    end

    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: assemble the four data words, checkword over the high byte
    // ------------------------------------------------------------------
    s3_t s3_reg, s3_next;
    logic [3:0][15:0] d;
    logic             c_prime;

    always_comb
    begin
        d[BLK_A] = pi_reg;
        c_prime  = 1'b0;
        case (s2_reg.cmd)
            CMD_PS:
            begin
                d[BLK_B] = {GT_0B, tp_reg, pty_reg, ta_reg, ms_reg, di_reg,
                            s2_reg.segment[1:0]};
                d[BLK_C] = pi_reg;
                d[BLK_D] = s2_reg.chars[31:16];
                c_prime  = 1'b1;
            end
            CMD_RT:
            begin
                d[BLK_B] = {GT_2A, tp_reg, pty_reg, s2_reg.text_ab, s2_reg.segment};
                d[BLK_C] = s2_reg.chars[31:16];
                d[BLK_D] = s2_reg.chars[15:0];
            end
            CMD_CT:
            begin
                d[BLK_B] = {GT_4A, tp_reg, pty_reg, 3'b000, s2_reg.dc[16:15]};
                d[BLK_C] = {s2_reg.dc[14:0], s2_reg.hour[4]};
                d[BLK_D] = {s2_reg.hour[3:0], s2_reg.minute, s2_reg.offs};
            end
            default:
            begin
                d[BLK_B] = '0;
                d[BLK_C] = '0;
                d[BLK_D] = '0;
            end
        endcase
    end

    always_comb
    begin
        s3_next.data    = d;
        s3_next.c_prime = c_prime;
        for (int k = 0; k < 4; k++)
        begin
            s3_next.crc[k] = crc_byte(10'h000, d[k][15:8]);
        end
    end

    assign s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: finish the checkword over the low byte, add the offsets,
    // hand the group to the serialiser which doubles as output register
    // ------------------------------------------------------------------
    grp_load_t        ld;
    logic [3:0][9:0]  ofs;

    assign ofs[BLK_A] = OFS_A;
    assign ofs[BLK_B] = OFS_B;
    assign ofs[BLK_C] = s3_reg.c_prime ? OFS_CP : OFS_C;
    assign ofs[BLK_D] = OFS_D;

    always_comb
    begin
        ld.valid = s3_valid_reg;
        for (int k = 0; k < 4; k++)
        begin
            ld.grp.blocks[k] = {s3_reg.data[k],
                                crc_byte(s3_reg.crc[k], s3_reg.data[k][7:0]) ^ ofs[k]};
        end
    end

    rgbe_block_ser u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld       (ld),
        .ld_ready (ser_ready),
        .blk      (blk)
    );

endmodule

### hdl/rgbe_checker.sv
`include "rds_group_block_encoder_assert.svh"

module rgbe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        blk_valid,
    input logic        blk_ready,
    input logic [25:0] blk_word,
    input logic [1:0]  blk_index,
    input logic        blk_last
);
    import rgbe_pkg::*;

    // Flag the last block exactly on block D
    `RGBE_ASSERT_NOW(a_last_on_d, blk_valid, blk_last == (blk_index == BLK_D), "last_block disagrees with block_index")

    // Blocks of a group follow in order with no gap
    `RGBE_ASSERT_NEXT(a_index_step, blk_valid && blk_ready && blk_index != BLK_D, blk_valid && blk_index == 2'($past(blk_index) + 2'd1), "block sequence broken")

    // A new group always opens on block A
    `RGBE_ASSERT_NEXT(a_group_start, blk_valid && blk_ready && blk_index == BLK_D, !blk_valid || blk_index == BLK_A, "group did not start at block A")

    // Hold a stalled block
    `RGBE_ASSERT_NEXT(a_stall_hold, blk_valid && !blk_ready, blk_valid && $stable(blk_word) && $stable(blk_index), "stalled block changed")

endmodule

bind rds_group_block_encoder rgbe_checker u_rgbe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .blk_valid (blk.valid),
    .blk_ready (blk.ready),
    .blk_word  (blk.block_word),
    .blk_index (blk.block_index),
    .blk_last  (blk.last_block)
);

### sim/rgbe_group_monitor.sv
module rgbe_group_monitor (
    input  logic clk,
    input  logic rst_n,
    rgbe_cfg_if  cfg,
    rgbe_req_if  req,
    rgbe_blk_if  blk,
    output int   failures,
    output int   blocks_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rgbe_pkg::*;

    // Offset words per block position
    localparam logic [9:0] OFFSET_A       = 10'h0FC;
    localparam logic [9:0] OFFSET_B       = 10'h198;
    localparam logic [9:0] OFFSET_C       = 10'h168;
    localparam logic [9:0] OFFSET_C_PRIME = 10'h350;
    localparam logic [9:0] OFFSET_D       = 10'h1B4;

    // Generator feedback taps, applied before the shift
    localparam logic [9:0] GEN_TAPS = 10'h0DC;

    // Group type and version heads, block B bits 15..11
    localparam logic [4:0] HEAD_0B = 5'b00001;
    localparam logic [4:0] HEAD_2A = 5'b00100;
    localparam logic [4:0] HEAD_4A = 5'b01000;

    typedef struct packed {
        logic [25:0] word;
        logic [1:0]  index;
        logic        last;
    } block_beat_t;

    block_beat_t blocks_due[$];

    logic [15:0] pi_code;
    logic        traffic_program;
    logic [4:0]  program_type;
    logic        traffic_announcement;
    logic        music_speech;
    logic        decoder_info;

    function automatic logic [25:0] protect_block(input logic [15:0] data,
                                                  input logic [9:0] offset);
        logic [9:0] syndrome;
        logic       fb;
        syndrome = '0;
        for (int i = 15; i >= 0; i--)
        begin
            fb = data[i] ^ syndrome[9];
            if (fb)
                syndrome = syndrome ^ GEN_TAPS;
            syndrome = {syndrome[8:0], fb};
        end
        return {data, syndrome ^ offset};
    endfunction

    // Modified Julian day, 365.25 and 30.6001 held as exact ratios
    function automatic logic [16:0] modified_julian_day(input logic [7:0] year,
                                                        input logic [3:0] month,
                                                        input logic [4:0] day);
        int leap;
        int years;
        int year_days;
        int month_days;
        int total;
        leap = (month == 4'd1 || month == 4'd2) ? 1 : 0;
        years = int'(year) - leap;
        if (years < 0)
            year_days = -(((-years) * 1461) / 4);
        else
            year_days = (years * 1461) / 4;
        month_days = ((int'(month) + 1 + 12 * leap) * 306001) / 10000;
        total = 14956 + int'(day) + year_days + month_days;
        return total[16:0];
    endfunction

    task automatic predict_group();
        logic [3:0][15:0] data;
        logic [9:0]       c_offset;
        logic [16:0]      mjd;
        block_beat_t      beat;
        c_offset = OFFSET_C;
        data[0] = pi_code;
        case (req.command)
            CMD_PS:
            begin
                data[1] = {HEAD_0B, traffic_program, program_type, traffic_announcement,
                           music_speech, decoder_info, req.segment[1:0]};
                data[2] = pi_code;
                data[3] = req.text_chars[31:16];
                c_offset = OFFSET_C_PRIME;
            end
            CMD_RT:
            begin
                data[1] = {HEAD_2A, traffic_program, program_type, req.text_ab, req.segment};
                data[2] = req.text_chars[31:16];
                data[3] = req.text_chars[15:0];
            end
            CMD_CT:
            begin
                mjd = modified_julian_day(req.year, req.month, req.day);
                data[1] = {HEAD_4A, traffic_program, program_type, 3'b000, mjd[16:15]};
                data[2] = {mjd[14:0], req.hour[4]};
                data[3] = {req.hour[3:0], req.minute, req.utc_offset[5:0]};
            end
            default:
                return; // unused command: dropped without output
        endcase
        beat.word = protect_block(data[0], OFFSET_A);
        beat.index = BLK_A;
        beat.last = 1'b0;
        blocks_due.push_back(beat);
        beat.word = protect_block(data[1], OFFSET_B);
        beat.index = BLK_B;
        blocks_due.push_back(beat);
        beat.word = protect_block(data[2], c_offset);
        beat.index = BLK_C;
        blocks_due.push_back(beat);
        beat.word = protect_block(data[3], OFFSET_D);
        beat.index = BLK_D;
        beat.last = 1'b1;
        blocks_due.push_back(beat);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        block_beat_t due;
        if (!rst_n)
        begin
            pi_code = '0;
            traffic_program = 1'b0;
            program_type = '0;
            traffic_announcement = 1'b0;
            music_speech = 1'b0;
            decoder_info = 1'b0;
            blocks_due.delete();
            failures = 0;
            blocks_pending = 0;
        end
        else
        begin
            if (blk.valid && blk.ready)
            begin
                if (blocks_due.size() == 0)
                begin
                    $display("%0t unexpected block: actual word %h index %0d last %0b",
                             $time, blk.block_word, blk.block_index, blk.last_block);
                    failures++;
                end
                else
                begin
                    due = blocks_due.pop_front();
                    if (blk.block_word !== due.word)
                    begin
                        $display("%0t block_word mismatch: expected %h, actual %h",
                                 $time, due.word, blk.block_word);
                        failures++;
                    end
                    if (blk.block_index !== due.index)
                    begin
                        $display("%0t block_index mismatch: expected %0d, actual %0d",
                                 $time, due.index, blk.block_index);
                        failures++;
                    end
                    if (blk.last_block !== due.last)
                    begin
                        $display("%0t last_block mismatch: expected %0b, actual %0b",
                                 $time, due.last, blk.last_block);
                        failures++;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_PI:  pi_code = cfg.data;
                    REG_TP:  traffic_program = cfg.data[0];
                    REG_PTY: program_type = cfg.data[4:0];
                    REG_TA:  traffic_announcement = cfg.data[0];
                    REG_MS:  music_speech = cfg.data[0];
                    REG_DI:  decoder_info = cfg.data[0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                predict_group();
            blocks_pending = blocks_due.size();
        end
    end

endmodule

### sim/tb_rds_group_block_encoder.sv
module tb_rds_group_block_encoder;
    timeunit 1ns;
    timeprecision 1ps;
    import rgbe_pkg::*;

    // Longest run of cycles without any beat before the run is abandoned
    localparam int STALL_LIMIT     = 2000;
    // Length of the deliberate back-pressure stretch on the block channel
    localparam int HOLD_OFF_CYCLES = 200;
    // Cycles to let pass once the last block is in, covering dropped requests
    localparam int SETTLE_CYCLES   = 8;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  segment;
        logic        text_ab;
        logic [31:0] text_chars;
        logic [7:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  utc_offset;
    } group_request_t;

    logic clk = 1'b0;
    logic rst_n;

    // Shared between the request and block sides
    bit burst_mode;        // no idling on either side while set
    bit hold_off_request;  // ask the block side for one long stall

    int monitor_failures;
    int blocks_pending;

    rgbe_cfg_if cfg_ch ();
    rgbe_req_if req_ch ();
    rgbe_blk_if blk_ch ();

    rds_group_block_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .blk   (blk_ch)
    );

    rgbe_group_monitor group_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_ch),
        .req            (req_ch),
        .blk            (blk_ch),
        .failures       (monitor_failures),
        .blocks_pending (blocks_pending)
    );

    always #10 clk = ~clk;

    function automatic group_request_t make_request(
        input logic [1:0] command, input logic [3:0] segment, input logic text_ab,
        input logic [31:0] text_chars, input logic [7:0] year, input logic [3:0] month,
        input logic [4:0] day, input logic [4:0] hour, input logic [5:0] minute,
        input logic [5:0] utc_offset);
        group_request_t r;
        r.command = command;
        r.segment = segment;
        r.text_ab = text_ab;
        r.text_chars = text_chars;
        r.year = year;
        r.month = month;
        r.day = day;
        r.hour = hour;
        r.minute = minute;
        r.utc_offset = utc_offset;
        return r;
    endfunction

    // Mostly calendar-valid dates and times; now and then any value the widths allow
    function automatic group_request_t random_request();
        group_request_t r;
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 5)
            r.command = CMD_PS;
        else if (pick < 10)
            r.command = CMD_RT;
        else if (pick < 15)
            r.command = CMD_CT;
        else
            r.command = CMD_NONE;
        r.segment = 4'($urandom());
        r.text_ab = 1'($urandom());
        r.text_chars = $urandom();
        r.year = 8'($urandom());
        r.month = ($urandom_range(0, 7) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 12));
        r.day = ($urandom_range(0, 7) == 0) ? 5'($urandom()) : 5'($urandom_range(1, 31));
        r.hour = ($urandom_range(0, 7) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 23));
        r.minute = ($urandom_range(0, 7) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 59));
        r.utc_offset = 6'($urandom());
        return r;
    endfunction

    // Present one request and hold it until the block takes the beat
    task automatic offer_request(input group_request_t r);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.command <= r.command;
        req_ch.segment <= r.segment;
        req_ch.text_ab <= r.text_ab;
        req_ch.text_chars <= r.text_chars;
        req_ch.year <= r.year;
        req_ch.month <= r.month;
        req_ch.day <= r.day;
        req_ch.hour <= r.hour;
        req_ch.minute <= r.minute;
        req_ch.utc_offset <= r.utc_offset;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            // flip between idling and back-to-back stretches
            if (n % 12 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            offer_request(random_request());
        end
        burst_mode = 1'b0;
    endtask

    task automatic write_register(input logic [2:0] index, input logic [15:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data <= data;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Upper data bits on the narrow registers are random so that masking is exercised
    task automatic apply_settings(input logic [15:0] pi, input logic tp, input logic [4:0] pty,
                                  input logic ta, input logic ms, input logic di);
        write_register(REG_PI, pi);
        write_register(REG_TP, {15'($urandom()), tp});
        write_register(REG_PTY, {11'($urandom()), pty});
        write_register(REG_TA, {15'($urandom()), ta});
        write_register(REG_MS, {15'($urandom()), ms});
        write_register(REG_DI, {15'($urandom()), di});
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop the request valid, let every outstanding group drain, then allow for
    // a dropped request still in flight
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (blocks_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_directed();
        // service name: all four segment addresses, upper segment bits ignored
        offer_request(make_request(CMD_PS, 4'd0, 1'b0, 32'hFFFF_FFFF, 8'd0, 4'd1, 5'd1,
                                   5'd0, 6'd0, 6'd0));
        offer_request(make_request(CMD_PS, 4'd3, 1'b1, 32'h0000_0000, 8'hFF, 4'd15, 5'd31,
                                   5'd31, 6'd63, 6'h3F));
        offer_request(make_request(CMD_PS, 4'hE, 1'b0, 32'h1234_ABCD, 8'd0, 4'd0, 5'd0,
                                   5'd0, 6'd0, 6'd0));
        offer_request(make_request(CMD_PS, 4'h5, 1'b1, 32'h80FF_7F01, 8'd0, 4'd0, 5'd0,
                                   5'd0, 6'd0, 6'd0));
        // radiotext: segment and A/B flag extremes, bytes with the top bit set
        offer_request(make_request(CMD_RT, 4'd0, 1'b0, 32'h0000_0000, 8'd0, 4'd0, 5'd0,
                                   5'd0, 6'd0, 6'd0));
        offer_request(make_request(CMD_RT, 4'd15, 1'b1, 32'hFFFF_FFFF, 8'hFF, 4'd15, 5'd31,
                                   5'd31, 6'd63, 6'h3F));
        offer_request(make_request(CMD_RT, 4'd10, 1'b1, 32'h807F_01FE, 8'd0, 4'd0, 5'd0,
                                   5'd0, 6'd0, 6'd0));
        offer_request(make_request(CMD_RT, 4'd1, 1'b0, 32'h00FF_00FF, 8'd0, 4'd0, 5'd0,
                                   5'd0, 6'd0, 6'd0));
        // clock time: year zero in January and February gives a negative year term
        offer_request(make_request(CMD_CT, 4'd0, 1'b0, 32'd0, 8'd0, 4'd1, 5'd1,
                                   5'd0, 6'd0, 6'd0));
        offer_request(make_request(CMD_CT, 4'd0, 1'b0, 32'd0, 8'd0, 4'd2, 5'd31,
                                   5'd23, 6'd59, 6'h20));
        offer_request(make_request(CMD_CT, 4'd0, 1'b0, 32'd0, 8'd1, 4'd1, 5'd1,
                                   5'd0, 6'd0, 6'd1));
        offer_request(make_request(CMD_CT, 4'd0, 1'b0, 32'd0, 8'd255, 4'd12, 5'd31,
                                   5'd23, 6'd59, 6'd31));
        offer_request(make_request(CMD_CT, 4'd0, 1'b0, 32'd0, 8'd255, 4'd1, 5'd31,
                                   5'd16, 6'd1, 6'h3F));
        offer_request(make_request(CMD_CT, 4'd0, 1'b0, 32'd0, 8'd124, 4'd3, 5'd15,
                                   5'd12, 6'd30, 6'h3E));
        // months outside the calendar, out-of-range day, hour and minute
        offer_request(make_request(CMD_CT, 4'd0, 1'b0, 32'd0, 8'd100, 4'd0, 5'd0,
                                   5'd24, 6'd60, 6'd0));
        offer_request(make_request(CMD_CT, 4'd0, 1'b0, 32'd0, 8'd50, 4'd13, 5'd10,
                                   5'd8, 6'd15, 6'd5));
        offer_request(make_request(CMD_CT, 4'd0, 1'b0, 32'd0, 8'd70, 4'd14, 5'd0,
                                   5'd16, 6'd0, 6'h10));
        offer_request(make_request(CMD_CT, 4'hF, 1'b1, 32'hFFFF_FFFF, 8'd255, 4'd15, 5'd31,
                                   5'd31, 6'd63, 6'h3F));
        // unused command, between groups that must still come out intact
        offer_request(make_request(CMD_NONE, 4'hF, 1'b1, 32'hFFFF_FFFF, 8'hFF, 4'hF, 5'h1F,
                                   5'h1F, 6'h3F, 6'h3F));
        offer_request(make_request(CMD_PS, 4'd2, 1'b0, 32'hA5A5_5A5A, 8'd0, 4'd0, 5'd0,
                                   5'd0, 6'd0, 6'd0));
        offer_request(make_request(CMD_NONE, 4'd0, 1'b0, 32'd0, 8'd0, 4'd0, 5'd0,
                                   5'd0, 6'd0, 6'd0));
    endtask

    // Block side: stall a random number of cycles per beat, or one long stretch on request
    initial
    begin : block_sink
        int stall;
        blk_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_request)
            begin
                stall = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            else
                stall = burst_mode ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                blk_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            blk_ch.ready <= 1'b1;
            do @(posedge clk); while (!blk_ch.valid);
        end
    end

    // Abandon the run after too long without a beat on any channel
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (blk_ch.valid && blk_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL rds_group_block_encoder");
        $finish;
    end

    initial
    begin : stimulus
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.command <= CMD_PS;
        req_ch.segment <= '0;
        req_ch.text_ab <= 1'b0;
        req_ch.text_chars <= '0;
        req_ch.year <= '0;
        req_ch.month <= '0;
        req_ch.day <= '0;
        req_ch.hour <= '0;
        req_ch.minute <= '0;
        req_ch.utc_offset <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_PI;
        cfg_ch.data <= '0;
        burst_mode = 1'b0;
        hold_off_request = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases run against the reset values of the registers
        run_directed();

        // every register at its top value
        settle();
        apply_settings(16'hFFFF, 1'b1, 5'd31, 1'b1, 1'b1, 1'b1);
        run_random(40);

        // everything back to zero, then fill the block while its output is held off
        settle();
        apply_settings(16'h0000, 1'b0, 5'd0, 1'b0, 1'b0, 1'b0);
        hold_off_request = 1'b1;
        burst_mode = 1'b1;
        for (int n = 0; n < 30; n++)
            offer_request(random_request());
        burst_mode = 1'b0;

        // random settings
        for (int p = 0; p < 3; p++)
        begin
            settle();
            apply_settings(16'($urandom()), 1'($urandom()), 5'($urandom()), 1'($urandom()),
                           1'($urandom()), 1'($urandom()));
            run_random(40);
        end

        // drain and give the verdict
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (blocks_pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (monitor_failures == 0 && blocks_pending == 0)
            $display("PASS rds_group_block_encoder");
        else
            $display("FAIL rds_group_block_encoder");
        $finish;
    end

endmodule
